>>> design/smvr_pkg.sv
// shared types and constants for the sample statistics block
package smvr_pkg;

   // result status codes
   localparam logic [1:0] STAT_OK      = 2'd0;
   localparam logic [1:0] STAT_SINGLE  = 2'd1;
   localparam logic [1:0] STAT_EMPTY   = 2'd2;
   localparam logic [1:0] STAT_DROPPED = 2'd3;

   // reference value after reset, 0.04123 m in Q7.16
   localparam logic signed [23:0] REF_RESET = 24'sd2702;

   // divide / square root unit geometry
   localparam int DS_WIDTH      = 64;
   localparam int DS_DIV_WIDTH  = 11;
   localparam int DS_REM_WIDTH  = 36;
   localparam int DS_DIV_STEPS  = 64;
   localparam int DS_SQRT_STEPS = 32;

   typedef struct packed {
      logic start;
      logic sqrt_mode;
   } ds_ctl_type;

endpackage

>>> design/smvr_divsqrt.sv
// shared restoring divider and floor square root, one result bit per cycle
module smvr_divsqrt (
   input  logic                                  clock,
   input  logic                                  reset,
   input  smvr_pkg::ds_ctl_type                  ctl,
   input  logic [smvr_pkg::DS_WIDTH-1:0]         operand,
   input  logic [smvr_pkg::DS_DIV_WIDTH-1:0]     divisor,
   output logic                                  done,
   output logic [smvr_pkg::DS_WIDTH-1:0]         result,
   output logic [smvr_pkg::DS_DIV_WIDTH-1:0]     remainder
);

   localparam int RW = smvr_pkg::DS_REM_WIDTH;
   localparam int W  = smvr_pkg::DS_WIDTH;

   logic                             busy_ff;
   logic                             mode_ff;
   logic                             done_ff;
   logic [5:0]                       step_ff;
   logic [W-1:0]                     x_ff;
   logic [W-1:0]                     q_ff;
   logic [RW-1:0]                    rem_ff;
   logic [smvr_pkg::DS_DIV_WIDTH-1:0] div_ff;

   logic [RW-1:0] wide;
   logic [RW-1:0] trial;
   logic [RW-1:0] diff;
   logic          ge;
   logic          last_step;

   // one shared compare and subtract serves both operations
   always_comb begin
      if (mode_ff) begin
         wide  = {rem_ff[RW-3:0], x_ff[W-1:W-2]};
         trial = {2'b00, q_ff[31:0], 2'b01};
      end else begin
         wide  = {rem_ff[RW-2:0], x_ff[W-1]};
         trial = RW'(div_ff);
      end
      ge        = (wide >= trial);
      diff      = wide - trial;
      last_step = mode_ff ? (step_ff == 6'(smvr_pkg::DS_SQRT_STEPS - 1))
                          : (step_ff == 6'(smvr_pkg::DS_DIV_STEPS - 1));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         done_ff <= 1'b0;
         if (ctl.start) begin
            busy_ff <= 1'b1;
            mode_ff <= ctl.sqrt_mode;
            step_ff <= '0;
            x_ff    <= operand;
            q_ff    <= '0;
            rem_ff  <= '0;
            div_ff  <= divisor;
         end else if (busy_ff) begin
            rem_ff  <= ge ? diff : wide;
            q_ff    <= {q_ff[W-2:0], ge};
            x_ff    <= mode_ff ? {x_ff[W-3:0], 2'b00} : {x_ff[W-2:0], 1'b0};
            step_ff <= step_ff + 6'd1;
            if (last_step) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   assign done      = done_ff;
   assign result    = q_ff;
   assign remainder = rem_ff[smvr_pkg::DS_DIV_WIDTH-1:0];

endmodule

>>> design/sample_mean_variance_rmse.sv
// sample count, mean, sample variance, standard deviation and rmse of a sample set
// an accumulated sample takes the transfer plus two squarings on the shared multiplier,
// a dropped one only the transfer; the result follows the transfer marked last through
// three 64-step divides and two 32-step roots on the shared unit (two divides with
// fewer than two samples kept). input is ready again the cycle after the result transfer.
// synchronous reset clears the sums and count and loads the reference with 2702.
module sample_mean_variance_rmse #(
   parameter int MAX_SAMPLES = 1024
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               csr_we,
   input  logic signed [23:0] csr_wdata,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic signed [23:0] req_sample,
   input  logic               req_last,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [10:0]        rsp_sample_count,
   output logic signed [23:0] rsp_mean_value,
   output logic [30:0]        rsp_variance,
   output logic [23:0]        rsp_std_dev,
   output logic [24:0]        rsp_rmse,
   output logic [1:0]         rsp_status
);

   typedef enum logic [3:0] {
      S_IDLE, S_MUL_SAMPLE, S_MUL_ERROR, S_FIN_ERR, S_MEAN_WAIT, S_MUL_QN,
      S_MUL_QNQ, S_MUL_QR, S_MUL_RR, S_MSE_WAIT, S_VAR_WAIT, S_MUL_MN,
      S_VAR_FIX, S_STD_WAIT, S_RMSE_WAIT, S_OUT
   } state_type;

   localparam logic [10:0] CAPACITY = 11'(MAX_SAMPLES);

   state_type          state_ff;
   logic signed [23:0] ref_ff;
   logic [10:0]        count_ff;
   logic signed [33:0] sum_ff;
   logic [56:0]        sumsq_ff;
   logic [59:0]        errsq_ff;
   logic               ovf_ff;
   logic signed [23:0] s_ff;
   logic signed [24:0] d_ff;
   logic               last_ff;
   logic               take_ff;
   logic               pend_ff;
   logic signed [60:0] prod_ff;
   logic signed [23:0] q_ff;
   logic signed [11:0] r_ff;
   logic signed [59:0] a_ff;
   logic [59:0]        mse_ff;
   logic [57:0]        k_ff;
   logic [9:0]         m_ff;
   logic [19:0]        rr_ff;
   logic [57:0]        var_ff;
   logic [23:0]        std_ff;
   logic [24:0]        rmse_ff;

   logic signed [35:0] mul_a;
   logic signed [24:0] mul_b;
   logic signed [60:0] mul_p;

   smvr_pkg::ds_ctl_type ds_ctl;
   logic [63:0]          ds_operand;
   logic [10:0]          ds_divisor;
   logic                 ds_done;
   logic [63:0]          ds_result;
   logic [10:0]          ds_rem;

   logic [33:0]        sum_mag;
   logic [59:0]        a_clamp;
   logic [57:0]        var_in;
   logic signed [23:0] q_in;
   logic signed [11:0] r_in;
   logic signed [24:0] cnt_s;

   smvr_divsqrt u_divsqrt (
      .clock     (clock),
      .reset     (reset),
      .ctl       (ds_ctl),
      .operand   (ds_operand),
      .divisor   (ds_divisor),
      .done      (ds_done),
      .result    (ds_result),
      .remainder (ds_rem)
   );

   always_comb begin
      cnt_s   = signed'({14'd0, count_ff});
      sum_mag = sum_ff[33] ? 34'(-sum_ff) : 34'(sum_ff);
      a_clamp = a_ff[59] ? '0 : 60'(a_ff);
      // truncating division: quotient and remainder take the sign of the sum
      q_in    = sum_ff[33] ? -signed'(ds_result[23:0]) : signed'(ds_result[23:0]);
      r_in    = sum_ff[33] ? -signed'({1'b0, ds_rem}) : signed'({1'b0, ds_rem});
      // step the quotient down when the remainder term does not cover r*r/n
      if (prod_ff[20:0] < {1'b0, rr_ff}) begin
         var_in = (k_ff == '0) ? '0 : k_ff - 58'd1;
      end else begin
         var_in = k_ff;
      end
   end

   // operand select for the shared multiplier
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      case (state_ff)
         S_MUL_SAMPLE: begin
            mul_a = 36'(s_ff);
            mul_b = 25'(s_ff);
         end
         S_MUL_ERROR: begin
            mul_a = 36'(d_ff);
            mul_b = d_ff;
         end
         S_MUL_QN: begin
            mul_a = 36'(q_ff);
            mul_b = cnt_s;
         end
         S_MUL_QNQ: begin
            mul_a = prod_ff[35:0];
            mul_b = 25'(q_ff);
         end
         S_MUL_QR: begin
            mul_a = 36'(q_ff);
            mul_b = 25'(r_ff);
         end
         S_MUL_RR: begin
            mul_a = 36'(r_ff);
            mul_b = 25'(r_ff);
         end
         S_MUL_MN: begin
            mul_a = signed'({26'd0, m_ff});
            mul_b = cnt_s;
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   assign mul_p = mul_a * mul_b;

   // divide / square root requests
   always_comb begin
      ds_ctl     = '0;
      ds_operand = '0;
      ds_divisor = count_ff;
      case (state_ff)
         S_FIN_ERR: begin
            ds_ctl.start = 1'b1;
            ds_operand   = 64'(sum_mag);
         end
         S_MEAN_WAIT: begin
            ds_ctl.start = ds_done;
            ds_operand   = 64'(errsq_ff);
         end
         S_MSE_WAIT: begin
            ds_ctl.start = ds_done;
            if (count_ff >= 11'd2) begin
               ds_operand = 64'(a_clamp);
               ds_divisor = count_ff - 11'd1;
            end else begin
               ds_ctl.sqrt_mode = 1'b1;
            end
         end
         S_VAR_FIX: begin
            ds_ctl.start     = 1'b1;
            ds_ctl.sqrt_mode = 1'b1;
            ds_operand       = 64'(var_in);
         end
         S_STD_WAIT: begin
            ds_ctl.start     = ds_done;
            ds_ctl.sqrt_mode = 1'b1;
            ds_operand       = 64'(mse_ff);
         end
         default: begin
            ds_ctl     = '0;
            ds_operand = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         ref_ff   <= smvr_pkg::REF_RESET;
         count_ff <= '0;
         sum_ff   <= '0;
         sumsq_ff <= '0;
         errsq_ff <= '0;
         ovf_ff   <= 1'b0;
         take_ff  <= 1'b0;
         pend_ff  <= 1'b0;
      end else begin
         if (csr_we) begin
            ref_ff <= csr_wdata;
         end
         case (state_ff)
            S_IDLE: begin
               // finish the error square of the previous sample
               if (pend_ff) begin
                  errsq_ff <= errsq_ff + 60'(prod_ff[56:0]);
                  pend_ff  <= 1'b0;
               end
               if (req_valid) begin
                  s_ff    <= req_sample;
                  d_ff    <= 25'(req_sample) - 25'(ref_ff);
                  last_ff <= req_last;
                  if (count_ff < CAPACITY) begin
                     count_ff <= count_ff + 11'd1;
                     sum_ff   <= sum_ff + 34'(req_sample);
                     take_ff  <= 1'b1;
                     state_ff <= S_MUL_SAMPLE;
                  end else begin
                     ovf_ff   <= 1'b1;
                     take_ff  <= 1'b0;
                     state_ff <= req_last ? S_FIN_ERR : S_IDLE;
                  end
               end
            end
            S_MUL_SAMPLE: begin
               prod_ff  <= mul_p;
               state_ff <= S_MUL_ERROR;
            end
            S_MUL_ERROR: begin
               sumsq_ff <= sumsq_ff + prod_ff[56:0];
               prod_ff  <= mul_p;
               if (last_ff) begin
                  state_ff <= S_FIN_ERR;
               end else begin
                  pend_ff  <= 1'b1;
                  state_ff <= S_IDLE;
               end
            end
            S_FIN_ERR: begin
               if (take_ff) begin
                  errsq_ff <= errsq_ff + 60'(prod_ff[56:0]);
               end
               state_ff <= S_MEAN_WAIT;
            end
            S_MEAN_WAIT: begin
               if (ds_done) begin
                  q_ff     <= q_in;
                  r_ff     <= r_in;
                  state_ff <= S_MUL_QN;
               end
            end
            S_MUL_QN: begin
               prod_ff  <= mul_p;
               state_ff <= S_MUL_QNQ;
            end
            S_MUL_QNQ: begin
               prod_ff  <= mul_p;
               state_ff <= S_MUL_QR;
            end
            S_MUL_QR: begin
               // a = sumsq - n*q*q - 2*q*r
               a_ff     <= signed'({3'b000, sumsq_ff}) - prod_ff[59:0];
               prod_ff  <= mul_p;
               state_ff <= S_MUL_RR;
            end
            S_MUL_RR: begin
               a_ff     <= a_ff - signed'({prod_ff[58:0], 1'b0});
               prod_ff  <= mul_p;
               state_ff <= S_MSE_WAIT;
            end
            S_MSE_WAIT: begin
               rr_ff <= prod_ff[19:0];
               if (ds_done) begin
                  mse_ff <= ds_result[59:0];
                  if (count_ff >= 11'd2) begin
                     state_ff <= S_VAR_WAIT;
                  end else begin
                     var_ff   <= '0;
                     state_ff <= S_STD_WAIT;
                  end
               end
            end
            S_VAR_WAIT: begin
               if (ds_done) begin
                  k_ff     <= ds_result[57:0];
                  m_ff     <= ds_rem[9:0];
                  state_ff <= S_MUL_MN;
               end
            end
            S_MUL_MN: begin
               prod_ff  <= mul_p;
               state_ff <= S_VAR_FIX;
            end
            S_VAR_FIX: begin
               var_ff   <= var_in;
               state_ff <= S_STD_WAIT;
            end
            S_STD_WAIT: begin
               if (ds_done) begin
                  std_ff   <= ds_result[23:0];
                  state_ff <= S_RMSE_WAIT;
               end
            end
            S_RMSE_WAIT: begin
               if (ds_done) begin
                  rmse_ff  <= ds_result[24:0];
                  state_ff <= S_OUT;
               end
            end
            S_OUT: begin
               if (rsp_ready) begin
                  count_ff <= '0;
                  sum_ff   <= '0;
                  sumsq_ff <= '0;
                  errsq_ff <= '0;
                  ovf_ff   <= 1'b0;
                  take_ff  <= 1'b0;
                  state_ff <= S_IDLE;
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   assign req_ready        = (state_ff == S_IDLE);
   assign rsp_valid        = (state_ff == S_OUT);
   assign rsp_sample_count = count_ff;
   assign rsp_mean_value   = (count_ff == '0) ? '0 : q_ff;
   assign rsp_variance     = var_ff[46:16];
   assign rsp_std_dev      = std_ff;
   assign rsp_rmse         = (count_ff == '0) ? '0 : rmse_ff;

   always_comb begin
      if (count_ff == '0) begin
         rsp_status = smvr_pkg::STAT_EMPTY;
      end else if (ovf_ff) begin
         rsp_status = smvr_pkg::STAT_DROPPED;
      end else if (count_ff == 11'd1) begin
         rsp_status = smvr_pkg::STAT_SINGLE;
      end else begin
         rsp_status = smvr_pkg::STAT_OK;
      end
   end

   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      !(req_ready && rsp_valid))
      else $error("input taken while a result is pending");

   a_capacity: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CAPACITY)
      else $error("sample count beyond capacity");

   a_clear_after_rsp: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_ready) |=> (count_ff == '0) && !ovf_ff)
      else $error("accumulators not cleared after result transfer");

   a_ok_needs_two: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_status == smvr_pkg::STAT_OK)) |-> (rsp_sample_count >= 11'd2))
      else $error("ok status with fewer than two samples");

endmodule
